/* rtl/core/sdh_pkg.sv */
package sdh_pkg;

  localparam logic [2:0] ACT_XCHG = 3'd0;
  localparam logic [2:0] ACT_TICK = 3'd1;
  localparam logic [2:0] ACT_INIT = 3'd2;
  localparam logic [2:0] ACT_READ = 3'd3;
  localparam logic [2:0] ACT_WRITE = 3'd4;
  localparam logic [2:0] ACT_CAP = 3'd5;

  localparam logic [2:0] REG_INIT_TO = 3'd0;
  localparam logic [2:0] REG_READY_TO = 3'd1;
  localparam logic [2:0] REG_TOKEN_TO = 3'd2;
  localparam logic [2:0] REG_RST_TRIES = 3'd3;
  localparam logic [2:0] REG_POLL_BYTES = 3'd4;
  localparam logic [2:0] REG_WAKE_BYTES = 3'd5;

  localparam logic [5:0] CMD_GO_IDLE = 6'd0;
  localparam logic [5:0] CMD_IF_COND = 6'd8;
  localparam logic [5:0] CMD_SEND_CSD = 6'd9;
  localparam logic [5:0] CMD_STOP = 6'd12;
  localparam logic [5:0] CMD_READ1 = 6'd17;
  localparam logic [5:0] CMD_READN = 6'd18;
  localparam logic [5:0] CMD_WRITE1 = 6'd24;
  localparam logic [5:0] CMD_WRITEN = 6'd25;
  localparam logic [5:0] CMD_SD_OP = 6'd41;
  localparam logic [5:0] CMD_APP = 6'd55;
  localparam logic [5:0] CMD_READ_OCR = 6'd58;

  localparam logic [7:0] TOK_START1 = 8'hFE;
  localparam logic [7:0] TOK_STARTN = 8'hFC;
  localparam logic [7:0] TOK_STOP = 8'hFD;
  localparam logic [7:0] IDLE_BYTE = 8'hFF;
  localparam logic [15:0] CNT_SAT = 16'hFFFF;

  typedef enum logic [1:0] {
    JOB_INIT,
    JOB_READ,
    JOB_WRITE,
    JOB_CAP
  } sdh_job_t;

  typedef struct packed {
    logic [15:0] init_to;
    logic [15:0] ready_to;
    logic [15:0] token_to;
    logic [3:0]  rst_tries;
    logic [3:0]  poll_bytes;
    logic [5:0]  wake_bytes;
  } sdh_cfg_t;

  typedef struct packed {
    logic [31:0] sector_total;
    logic [1:0]  card_kind;
    logic        fail;
    logic        done_res;
    logic        busy_res;
    logic        read_valid;
    logic [7:0]  read_data;
    logic        need_write_data;
    logic        fast_clock;
    logic        select_active;
    logic        exchange_next;
    logic [7:0]  mosi_byte;
  } sdh_res_t;

endpackage

/* rtl/core/sdh_core.sv */
module sdh_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [2:0]        action,
  input  logic [7:0]        miso_byte,
  input  logic [31:0]       sector,
  input  logic [31:0]       block_count,
  input  logic [7:0]        write_byte,
  input  sdh_pkg::sdh_cfg_t cfg,
  output sdh_pkg::sdh_res_t res
);
  import sdh_pkg::*;

  typedef enum logic [4:0] {
    P_IDLE, P_WAKE, P_C_DESEL, P_C_WAIT, P_C_FRAME, P_C_SKIP, P_C_POLL,
    P_I_R7, P_I_OCR, P_R_TOKEN, P_R_DATA, P_R_CRC,
    P_W_READY, P_W_TOKEN, P_W_DATA, P_W_CRC, P_W_RESP, P_W_BUSY,
    P_W_STOPFF, P_W_STOPWAIT, P_FINAL
  } phase_t;

  phase_t      ph_r, ph_nxt;
  logic [1:0]  kind_r, kind_nxt, ik_r, ik_nxt;
  logic [9:0]  bi_r, bi_nxt;
  logic [31:0] bl_r, bl_nxt, rw_r, rw_nxt, arg_r, arg_nxt;
  logic [15:0] el_r, el_nxt, loop_r, loop_nxt;
  logic [3:0]  rc_r, rc_nxt;
  logic [5:0]  cmd_r, cmd_nxt;
  sdh_job_t    job_r, job_nxt;
  logic [7:0]  tok_r, tok_nxt, pm_r, pm_nxt;
  logic        ff_r, ff_nxt, multi_r, multi_nxt;
  logic        px_r, px_nxt, psel_r, psel_nxt, pneed_r, pneed_nxt;
  logic [7:0]  csd_r [16];
  logic        csd_we;

  logic        st_cmd, fin, cdone, rend, rend_ok, send, send_ok, strecv, stsend;
  logic [5:0]  st_idx;
  logic [31:0] st_arg, addr;
  logic [7:0]  stsend_tok, fbyte;
  logic [7:0]  ev_rdata;
  logic [31:0] ev_total;
  logic        ev_rvalid, ev_done;
  logic [4:0]  csd_n;
  logic [11:0] csd_cs1;
  logic [21:0] csd_cs2;
  logic [32:0] cap_v2;
  logic [31:0] cap_v1;

  function automatic logic expired(input logic [15:0] t, input logic [15:0] lim);
    return (t > lim) || (t == CNT_SAT);
  endfunction

  always_comb begin
    case (bi_r)
      10'd0:   fbyte = {2'b01, cmd_r};
      10'd1:   fbyte = arg_r[31:24];
      10'd2:   fbyte = arg_r[23:16];
      10'd3:   fbyte = arg_r[15:8];
      10'd4:   fbyte = arg_r[7:0];
      default: fbyte = (cmd_r == CMD_GO_IDLE) ? 8'h95 :
                       ((cmd_r == CMD_IF_COND) ? 8'h87 : 8'h01);
    endcase
  end

  // frame byte for index after increment
  logic [7:0] fbyte_nx;
  always_comb begin
    case (bi_r + 10'd1)
      10'd1:   fbyte_nx = arg_r[31:24];
      10'd2:   fbyte_nx = arg_r[23:16];
      10'd3:   fbyte_nx = arg_r[15:8];
      10'd4:   fbyte_nx = arg_r[7:0];
      default: fbyte_nx = (cmd_r == CMD_GO_IDLE) ? 8'h95 :
                          ((cmd_r == CMD_IF_COND) ? 8'h87 : 8'h01);
    endcase
  end

  always_comb begin
    csd_n = {1'b0, csd_r[5][3:0]} + {4'd0, csd_r[10][7]} + {2'd0, csd_r[9][1:0], 1'b0} + 5'd2;
    csd_cs1 = {csd_r[6][1:0], csd_r[7], csd_r[8][7:6]};
    csd_cs2 = {csd_r[7][5:0], csd_r[8], csd_r[9]};
    cap_v2 = {1'b0, 10'd0, csd_cs2} + 33'd1;
    cap_v2 = cap_v2 << 10;
    cap_v1 = ({19'd0, csd_cs1} + 32'd1) << (csd_n - 5'd9);
  end

  always_comb begin
    ph_nxt = ph_r; kind_nxt = kind_r; ik_nxt = ik_r; bi_nxt = bi_r; bl_nxt = bl_r;
    rw_nxt = rw_r; arg_nxt = arg_r; el_nxt = el_r; loop_nxt = loop_r; rc_nxt = rc_r;
    cmd_nxt = cmd_r; job_nxt = job_r; tok_nxt = tok_r; pm_nxt = pm_r; ff_nxt = ff_r;
    multi_nxt = multi_r; px_nxt = px_r; psel_nxt = psel_r; pneed_nxt = pneed_r;
    st_cmd = 1'b0; st_idx = CMD_GO_IDLE; st_arg = '0; fin = 1'b0; cdone = 1'b0;
    rend = 1'b0; rend_ok = 1'b0; send = 1'b0; send_ok = 1'b0; strecv = 1'b0;
    stsend = 1'b0; stsend_tok = TOK_START1; csd_we = 1'b0;
    ev_rdata = '0; ev_total = '0; ev_rvalid = 1'b0; ev_done = 1'b0;
    addr = (kind_r == 2'd3) ? sector : {sector[22:0], 9'd0};

    if (action == ACT_TICK) begin
      if (el_r != CNT_SAT) el_nxt = el_r + 16'd1;
      if (loop_r != CNT_SAT) loop_nxt = loop_r + 16'd1;
    end else if (action == ACT_XCHG) begin
      if (ph_r != P_IDLE && px_r) begin
        case (ph_r)
          P_WAKE: begin
            bi_nxt = bi_r + 10'd1;
            if (bi_nxt < {4'd0, cfg.wake_bytes}) begin
              px_nxt = 1'b1; pm_nxt = IDLE_BYTE; psel_nxt = 1'b0; pneed_nxt = 1'b0;
            end else begin
              rc_nxt = '0; st_cmd = 1'b1; st_idx = CMD_GO_IDLE;
            end
          end
          P_C_DESEL: begin
            ph_nxt = P_C_WAIT; el_nxt = '0;
            pm_nxt = IDLE_BYTE; psel_nxt = 1'b1; pneed_nxt = 1'b0;
          end
          P_C_WAIT: begin
            psel_nxt = 1'b1; pneed_nxt = 1'b0;
            if (miso_byte == IDLE_BYTE || expired(el_r, cfg.ready_to)) begin
              ph_nxt = P_C_FRAME; bi_nxt = '0; pm_nxt = {2'b01, cmd_r};
            end else pm_nxt = IDLE_BYTE;
          end
          P_C_FRAME: begin
            bi_nxt = bi_r + 10'd1;
            psel_nxt = 1'b1; pneed_nxt = 1'b0;
            if (bi_nxt < 10'd6) pm_nxt = fbyte_nx;
            else begin
              ph_nxt = (cmd_r == CMD_STOP) ? P_C_SKIP : P_C_POLL;
              bi_nxt = '0; pm_nxt = IDLE_BYTE;
            end
          end
          P_C_SKIP: begin
            ph_nxt = P_C_POLL; bi_nxt = '0;
            pm_nxt = IDLE_BYTE; psel_nxt = 1'b1; pneed_nxt = 1'b0;
          end
          P_C_POLL: begin
            bi_nxt = bi_r + 10'd1;
            if (!miso_byte[7] || bi_nxt >= {6'd0, cfg.poll_bytes}) cdone = 1'b1;
            else begin
              pm_nxt = IDLE_BYTE; psel_nxt = 1'b1; pneed_nxt = 1'b0;
            end
          end
          P_I_R7, P_I_OCR: begin
            rw_nxt = {rw_r[23:0], miso_byte};
            bi_nxt = bi_r + 10'd1;
            if (bi_nxt < 10'd4) begin
              pm_nxt = IDLE_BYTE; psel_nxt = 1'b1; pneed_nxt = 1'b0;
            end else if (ph_r == P_I_OCR) begin
              if (rw_nxt[30]) ik_nxt = 2'd3;
              fin = 1'b1;
            end else if (rw_nxt[15:0] == 16'h01AA) begin
              ik_nxt = 2'd2; loop_nxt = '0; st_cmd = 1'b1; st_idx = CMD_APP;
            end else begin
              ik_nxt = 2'd0; fin = 1'b1;
            end
          end
          P_R_TOKEN: begin
            if (expired(el_r, cfg.token_to)) rend = 1'b1;
            else if (miso_byte == IDLE_BYTE) begin
              pm_nxt = IDLE_BYTE; psel_nxt = 1'b1; pneed_nxt = 1'b0;
            end else if (miso_byte != TOK_START1) rend = 1'b1;
            else begin
              ph_nxt = P_R_DATA; bi_nxt = '0;
              pm_nxt = IDLE_BYTE; psel_nxt = 1'b1; pneed_nxt = 1'b0;
            end
          end
          P_R_DATA: begin
            if (job_r == JOB_CAP) csd_we = 1'b1;
            else begin
              ev_rvalid = 1'b1; ev_rdata = miso_byte;
            end
            bi_nxt = bi_r + 10'd1;
            if ((job_r == JOB_CAP) ? (bi_nxt >= 10'd16) : (bi_nxt >= 10'd512)) begin
              ph_nxt = P_R_CRC; bi_nxt = '0;
            end
            pm_nxt = IDLE_BYTE; psel_nxt = 1'b1; pneed_nxt = 1'b0;
          end
          P_R_CRC: begin
            bi_nxt = bi_r + 10'd1;
            if (bi_nxt < 10'd2) begin
              pm_nxt = IDLE_BYTE; psel_nxt = 1'b1; pneed_nxt = 1'b0;
            end else begin
              rend = 1'b1; rend_ok = 1'b1;
            end
          end
          P_W_READY: begin
            if (miso_byte == IDLE_BYTE) begin
              ph_nxt = P_W_TOKEN; pm_nxt = tok_r; psel_nxt = 1'b1;
              pneed_nxt = (tok_r != TOK_STOP);
            end else if (expired(el_r, cfg.ready_to)) send = 1'b1;
            else begin
              pm_nxt = IDLE_BYTE; psel_nxt = 1'b1; pneed_nxt = 1'b0;
            end
          end
          P_W_TOKEN: begin
            psel_nxt = 1'b1;
            if (tok_r == TOK_STOP) begin
              ph_nxt = P_W_STOPFF; pm_nxt = IDLE_BYTE; pneed_nxt = 1'b0;
            end else begin
              ph_nxt = P_W_DATA; bi_nxt = '0; pm_nxt = write_byte; pneed_nxt = 1'b1;
            end
          end
          P_W_DATA: begin
            bi_nxt = bi_r + 10'd1;
            psel_nxt = 1'b1;
            if (bi_nxt < 10'd512) begin
              pm_nxt = write_byte; pneed_nxt = (bi_nxt < 10'd511);
            end else begin
              ph_nxt = P_W_CRC; bi_nxt = '0; pm_nxt = IDLE_BYTE; pneed_nxt = 1'b0;
            end
          end
          P_W_CRC: begin
            bi_nxt = bi_r + 10'd1;
            if (bi_nxt >= 10'd2) ph_nxt = P_W_RESP;
            pm_nxt = IDLE_BYTE; psel_nxt = 1'b1; pneed_nxt = 1'b0;
          end
          P_W_RESP: begin
            if (miso_byte[4:0] != 5'h05) send = 1'b1;
            else begin
              ph_nxt = P_W_BUSY; el_nxt = '0;
              pm_nxt = IDLE_BYTE; psel_nxt = 1'b1; pneed_nxt = 1'b0;
            end
          end
          P_W_BUSY: begin
            if (miso_byte == IDLE_BYTE) begin
              send = 1'b1; send_ok = 1'b1;
            end else if (expired(el_r, cfg.ready_to)) send = 1'b1;
            else begin
              pm_nxt = IDLE_BYTE; psel_nxt = 1'b1; pneed_nxt = 1'b0;
            end
          end
          P_W_STOPFF: begin
            ph_nxt = P_W_STOPWAIT; el_nxt = '0;
            pm_nxt = IDLE_BYTE; psel_nxt = 1'b1; pneed_nxt = 1'b0;
          end
          P_W_STOPWAIT: begin
            if (miso_byte == IDLE_BYTE || expired(el_r, cfg.ready_to)) begin
              send = 1'b1; send_ok = 1'b1;
            end else begin
              pm_nxt = IDLE_BYTE; psel_nxt = 1'b1; pneed_nxt = 1'b0;
            end
          end
          default: begin
            ph_nxt = P_IDLE; px_nxt = 1'b0; pm_nxt = IDLE_BYTE;
            psel_nxt = 1'b0; pneed_nxt = 1'b0; ev_done = 1'b1;
            if (job_r == JOB_INIT) begin
              kind_nxt = ik_r; ff_nxt = (ik_r == 2'd0);
            end
            if (job_r == JOB_CAP && !ff_r) ev_total = rw_r;
          end
        endcase
      end
    end else if (action <= ACT_CAP && ph_r == P_IDLE) begin
      ff_nxt = 1'b0;
      if (action == ACT_INIT) begin
        job_nxt = JOB_INIT; kind_nxt = '0; ik_nxt = '0; ph_nxt = P_WAKE; bi_nxt = '0;
        px_nxt = 1'b1; pm_nxt = IDLE_BYTE; psel_nxt = 1'b0; pneed_nxt = 1'b0;
      end else if (kind_r == 2'd0 || (action != ACT_CAP && block_count == '0)) begin
        ff_nxt = 1'b1; ev_done = 1'b1;
      end else if (action == ACT_CAP) begin
        job_nxt = JOB_CAP; rw_nxt = '0; st_cmd = 1'b1; st_idx = CMD_SEND_CSD;
      end else begin
        bl_nxt = block_count; multi_nxt = (block_count != 32'd1);
        st_cmd = 1'b1; st_arg = addr;
        if (action == ACT_READ) begin
          job_nxt = JOB_READ; st_idx = multi_nxt ? CMD_READN : CMD_READ1;
        end else begin
          job_nxt = JOB_WRITE; st_idx = multi_nxt ? CMD_WRITEN : CMD_WRITE1;
        end
      end
    end

    if (cdone) begin
      case (cmd_r)
        CMD_GO_IDLE: begin
          if (miso_byte == 8'h01) begin
            st_cmd = 1'b1; st_idx = CMD_IF_COND; st_arg = 32'h1AA;
          end else begin
            rc_nxt = rc_r + 4'd1;
            if (rc_nxt < cfg.rst_tries) begin
              st_cmd = 1'b1; st_idx = CMD_GO_IDLE;
            end else fin = 1'b1;
          end
        end
        CMD_IF_COND: begin
          if (miso_byte == 8'h01) begin
            ph_nxt = P_I_R7; bi_nxt = '0; rw_nxt = '0;
            pm_nxt = IDLE_BYTE; psel_nxt = 1'b1; pneed_nxt = 1'b0;
          end else begin
            ik_nxt = 2'd1; loop_nxt = '0; st_cmd = 1'b1; st_idx = CMD_APP;
          end
        end
        CMD_APP: begin
          st_cmd = 1'b1; st_idx = CMD_SD_OP;
          st_arg = (ik_r == 2'd2) ? 32'h4000_0000 : 32'd0;
        end
        CMD_SD_OP: begin
          if (expired(loop_r, cfg.init_to)) begin
            ik_nxt = '0; fin = 1'b1;
          end else if (miso_byte == 8'h01) begin
            st_cmd = 1'b1; st_idx = CMD_APP;
          end else if (ik_r == 2'd2 && miso_byte == 8'h00) begin
            st_cmd = 1'b1; st_idx = CMD_READ_OCR;
          end else fin = 1'b1;
        end
        CMD_READ_OCR: begin
          ph_nxt = P_I_OCR; bi_nxt = '0; rw_nxt = '0;
          pm_nxt = IDLE_BYTE; psel_nxt = 1'b1; pneed_nxt = 1'b0;
        end
        CMD_SEND_CSD, CMD_READ1, CMD_READN: begin
          if (miso_byte == 8'h00) strecv = 1'b1;
          else begin
            ff_nxt = 1'b1; fin = 1'b1;
          end
        end
        CMD_WRITE1, CMD_WRITEN: begin
          if (miso_byte == 8'h00) begin
            stsend = 1'b1; stsend_tok = multi_r ? TOK_STARTN : TOK_START1;
          end else begin
            ff_nxt = 1'b1; fin = 1'b1;
          end
        end
        default: fin = 1'b1;
      endcase
    end

    if (send) begin
      if (tok_r == TOK_STOP) fin = 1'b1;
      else if (!send_ok) begin
        ff_nxt = 1'b1;
        if (multi_r) begin
          stsend = 1'b1; stsend_tok = TOK_STOP;
        end else fin = 1'b1;
      end else if (!multi_r) fin = 1'b1;
      else begin
        bl_nxt = bl_r - 32'd1;
        stsend = 1'b1; stsend_tok = (bl_nxt != '0) ? TOK_STARTN : TOK_STOP;
      end
    end

    if (rend) begin
      if (job_r == JOB_CAP) begin
        if (rend_ok) begin
          if (csd_r[0][7:6] == 2'b01) rw_nxt = cap_v2[31:0];
          else if (csd_n < 5'd9) begin
            ff_nxt = 1'b1; rw_nxt = '0;
          end else rw_nxt = cap_v1;
        end else ff_nxt = 1'b1;
        fin = 1'b1;
      end else begin
        if (!rend_ok) ff_nxt = 1'b1;
        else bl_nxt = bl_r - 32'd1;
        if (rend_ok && bl_nxt != '0) strecv = 1'b1;
        else if (multi_r) begin
          st_cmd = 1'b1; st_idx = CMD_STOP;
        end else fin = 1'b1;
      end
    end

    if (strecv) begin
      ph_nxt = P_R_TOKEN; el_nxt = '0; bi_nxt = '0;
      px_nxt = 1'b1; pm_nxt = IDLE_BYTE; psel_nxt = 1'b1; pneed_nxt = 1'b0;
    end
    if (stsend) begin
      tok_nxt = stsend_tok; ph_nxt = P_W_READY; el_nxt = '0;
      px_nxt = 1'b1; pm_nxt = IDLE_BYTE; psel_nxt = 1'b1; pneed_nxt = 1'b0;
    end
    if (st_cmd) begin
      cmd_nxt = st_idx; arg_nxt = st_arg; ph_nxt = P_C_DESEL;
      px_nxt = 1'b1; pm_nxt = IDLE_BYTE; psel_nxt = 1'b0; pneed_nxt = 1'b0;
    end
    if (fin) begin
      ph_nxt = P_FINAL;
      px_nxt = 1'b1; pm_nxt = IDLE_BYTE; psel_nxt = 1'b0; pneed_nxt = 1'b0;
    end

    res.mosi_byte = px_nxt ? pm_nxt : IDLE_BYTE;
    res.exchange_next = px_nxt;
    res.select_active = px_nxt && psel_nxt;
    res.fast_clock = (kind_nxt != 2'd0);
    res.need_write_data = px_nxt && pneed_nxt;
    res.read_data = ev_rdata;
    res.read_valid = ev_rvalid;
    res.busy_res = (ph_nxt != P_IDLE);
    res.done_res = ev_done;
    res.fail = ev_done && ff_nxt;
    res.card_kind = kind_nxt;
    res.sector_total = ev_total;
  end

  always_ff @(posedge clk) begin
    if (step && csd_we) csd_r[bi_r[3:0]] <= miso_byte;
    if (!rst_n) begin
      ph_r <= P_IDLE; kind_r <= '0; ik_r <= '0; bi_r <= '0; bl_r <= '0; rw_r <= '0;
      arg_r <= '0; el_r <= '0; loop_r <= '0; rc_r <= '0; cmd_r <= '0; job_r <= JOB_INIT;
      tok_r <= '0; pm_r <= IDLE_BYTE; ff_r <= 1'b0; multi_r <= 1'b0;
      px_r <= 1'b0; psel_r <= 1'b0; pneed_r <= 1'b0;
    end else if (step) begin
      ph_r <= ph_nxt; kind_r <= kind_nxt; ik_r <= ik_nxt; bi_r <= bi_nxt; bl_r <= bl_nxt;
      rw_r <= rw_nxt; arg_r <= arg_nxt; el_r <= el_nxt; loop_r <= loop_nxt; rc_r <= rc_nxt;
      cmd_r <= cmd_nxt; job_r <= job_nxt; tok_r <= tok_nxt; pm_r <= pm_nxt;
      ff_r <= ff_nxt; multi_r <= multi_nxt;
      px_r <= px_nxt; psel_r <= psel_nxt; pneed_r <= pneed_nxt;
    end
  end

  logic unused_fbyte;
  assign unused_fbyte = ^fbyte;

endmodule

/* rtl/core/sd_card_spi_host_engine.sv */
// SD card host engine, SPI mode, one byte exchange per input transaction.
// Input stream: in_tuser carries the action (exchange done, 1 ms tick, init,
// read, write, capacity); in_tdata carries the received byte, the sector, the
// block count and the next write byte. Each accepted input transaction gives
// exactly one output transaction: the next byte to shift with its chip select
// and clock choice, any read payload byte, and request status.
// The result is in the output register in the cycle after input acceptance.
// Throughput: one transaction per cycle while the receiver takes each result, set
// by the single state update between the state registers and the output register.
// When the receiver stalls, the output register holds its result and the
// input is still taken in the cycle the result leaves, so no bubble appears.
// Configuration writes (cfg_index 0..5) are always accepted and must be
// issued while the engine is idle.
// Reset (rst_n low, synchronous) returns to idle with no card known, output
// register empty and all timeouts and counts at their default values.
module sd_card_spi_host_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] miso_byte, [39:8] sector, [71:40] block_count, [79:72] write_byte
  input  logic [79:0] in_tdata,
  // [2:0] action
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] mosi_byte, [8] exchange_next, [9] select_active, [10] fast_clock,
  // [11] need_write_data, [19:12] read_data, [20] read_valid, [21] busy_res,
  // [22] done_res, [23] fail, [25:24] card_kind, [57:26] sector_total, rest 0
  output logic [63:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import sdh_pkg::*;

  sdh_cfg_t cfg_r;
  sdh_res_t res, res_r;
  logic     out_valid_r, step;

  assign in_tready = !out_valid_r || out_tready;
  assign step = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.init_to <= 16'd1000;
      cfg_r.ready_to <= 16'd500;
      cfg_r.token_to <= 16'd200;
      cfg_r.rst_tries <= 4'd10;
      cfg_r.poll_bytes <= 4'd10;
      cfg_r.wake_bytes <= 6'd10;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_INIT_TO:    cfg_r.init_to <= cfg_data;
        REG_READY_TO:   cfg_r.ready_to <= cfg_data;
        REG_TOKEN_TO:   cfg_r.token_to <= cfg_data;
        REG_RST_TRIES:  cfg_r.rst_tries <= cfg_data[3:0];
        REG_POLL_BYTES: cfg_r.poll_bytes <= cfg_data[3:0];
        REG_WAKE_BYTES: cfg_r.wake_bytes <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  sdh_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .action      (in_tuser),
    .miso_byte   (in_tdata[7:0]),
    .sector      (in_tdata[39:8]),
    .block_count (in_tdata[71:40]),
    .write_byte  (in_tdata[79:72]),
    .cfg         (cfg_r),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (step) res_r <= res;
    if (!rst_n) out_valid_r <= 1'b0;
    else if (step) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {6'd0, res_r.sector_total, res_r.card_kind, res_r.fail,
                      res_r.done_res, res_r.busy_res, res_r.read_valid, res_r.read_data,
                      res_r.need_write_data, res_r.fast_clock, res_r.select_active,
                      res_r.exchange_next, res_r.mosi_byte};

endmodule

/* rtl/core/sdh_checker.sv */
module sdh_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed while stalled");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[22] |-> !out_tdata[21])
    else $error("done while busy");

  a_fail_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[23] |-> out_tdata[22])
    else $error("fail without done");

  a_no_xchg: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[8] |-> out_tdata[7:0] == 8'hFF && !out_tdata[9])
    else $error("idle byte fields wrong");

endmodule

bind sd_card_spi_host_engine sdh_checker u_sdh_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
